// ===== rtl/core/sdcm_pkg.sv =====
// Package: sizes, item codes and shared types of the sparse-dense cyclic GF(2) multiplier.
`default_nettype none

package sdcm_pkg;

	// Polynomial and word geometry
	localparam int POLY_BITS  = 17669;
	localparam int POLY_WORDS = 277;
	localparam int WORD_BITS  = 64;
	localparam int IDX_W      = 9;
	localparam int POS_W      = 15;
	localparam int OFF_W      = 6;
	localparam int LEN_W      = OFF_W + 1;

	localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(POLY_WORDS - 1);
	localparam logic [IDX_W-1:0] NUM_WORDS = IDX_W'(POLY_WORDS);
	localparam logic [POS_W-1:0] NUM_BITS  = POS_W'(POLY_BITS);

	// Valid bits in the top word, and the mask that keeps them
	localparam int TOP_REM = POLY_BITS % WORD_BITS;
	localparam logic [LEN_W-1:0] TOP_LEN  = LEN_W'((TOP_REM == 0) ? WORD_BITS : TOP_REM);
	localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(WORD_BITS);
	localparam logic [WORD_BITS-1:0] TOP_MASK =
		(TOP_REM == 0) ? {WORD_BITS{1'b1}} : ((WORD_BITS'(1) << TOP_REM) - WORD_BITS'(1));

	// Item codes
	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_TERM  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	// Control into the stream packer
	typedef struct packed {
		logic valid;
		logic first;
		logic top;
	} pk_ctl_t;

	// Aligned word out of the stream packer
	typedef struct packed {
		logic                 emit;
		logic [WORD_BITS-1:0] data;
	} pk_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/sdcm_item_if.sv =====
// Interface: input item channel (valid/ready plus item fields).
`default_nettype none

interface sdcm_item_if
	import sdcm_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [1:0]           kind;
	logic [IDX_W-1:0]     word_index;
	logic [WORD_BITS-1:0] dense_word;
	logic [POS_W-1:0]     position;

	modport source (output valid, output kind, output word_index, output dense_word,
		output position, input ready);
	modport sink (input valid, input kind, input word_index, input dense_word,
		input position, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sdcm_result_if.sv =====
// Interface: result channel (valid/ready plus result word).
`default_nettype none

interface sdcm_result_if
	import sdcm_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] result_word;

	modport source (output valid, output result_word, input ready);
	modport sink (input valid, input result_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sdcm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module sdcm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 277
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

`default_nettype wire

// ===== rtl/core/sdcm_packer.sv =====
// Stream packer: turns the cyclic dense word stream into 64-bit words at any bit offset.
`default_nettype none

module sdcm_packer
	import sdcm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  pk_ctl_t              ctl,
	input  logic [OFF_W-1:0]     off,
	input  logic [WORD_BITS-1:0] word,
	output pk_out_t              out
);
	// Held bits (fewer than one word) and their count; bits above the count are zero
	logic [WORD_BITS-1:0]   hold_q;
	logic [OFF_W-1:0]       cnt_q;

	logic [WORD_BITS-1:0]   shifted;
	logic [LEN_W-1:0]       base_len;
	logic [LEN_W-1:0]       len;
	logic [OFF_W-1:0]       cnt;
	logic [WORD_BITS-1:0]   held;
	logic [2*WORD_BITS-1:0] merged;
	logic [LEN_W-1:0]       total;

	// First word drops the bits below the start offset; the top word is short
	always_comb begin
		shifted  = ctl.first ? (word >> off) : word;
		base_len = ctl.top ? TOP_LEN : FULL_LEN;
		len      = ctl.first ? (base_len - {1'b0, off}) : base_len;
		cnt      = ctl.first ? '0 : cnt_q;
		held     = ctl.first ? '0 : hold_q;
		merged   = {{WORD_BITS{1'b0}}, held} | ({{WORD_BITS{1'b0}}, shifted} << cnt);
		total    = {1'b0, cnt} + len;
	end

	assign out.emit = ctl.valid & total[LEN_W-1];
	assign out.data = merged[WORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.valid) begin
			cnt_q <= total[OFF_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			hold_q <= total[LEN_W-1] ? merged[2*WORD_BITS-1:WORD_BITS] : merged[WORD_BITS-1:0];
		end
	end
endmodule

`default_nettype wire

// ===== rtl/core/sparse_dense_cyclic_gf2_multiply_core.sv =====
// Top level: sparse-by-dense cyclic GF(2) product modulo X^n - 1, one word per cycle.
//
//  channel  | dir | beat carries                                   | handshake
//  ---------+-----+------------------------------------------------+-------------
//  items    | in  | kind, word_index, dense_word, position         | valid/ready
//  results  | out | result_word (one beat per read item)           | valid/ready
//
// Load: block stays ready. Read: the result beat comes through the accumulator RAM read port
//   and the result register; the block stays busy until that register is free.
// Term: sweeps the 277 accumulator words once, one word a cycle through the dense RAM read,
//   the packer and a read-modify-write of the accumulator.
// Clear: one accumulator word zeroed per cycle, then ready.
// Reset runs the same 277-word clearing pass; items wait until it ends.
// A waiting result stalls only the next read item; other items go on.
`default_nettype none

module sparse_dense_cyclic_gf2_multiply_core
	import sdcm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	sdcm_item_if.sink     items,
	sdcm_result_if.source results
);
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CLEAR = 5'b00010,
		ST_TERM  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_RDOUT = 5'b10000
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     wcnt_q;
	logic [IDX_W-1:0]     ra_q;
	logic [OFF_W-1:0]     off_q;
	logic                 first_q;
	logic                 rv_s1;
	logic                 rfirst_s1;
	logic                 rtop_s1;
	logic                 ew_v_s1;
	logic [IDX_W-1:0]     ew_idx_s1;
	logic [WORD_BITS-1:0] ew_s1;
	logic                 roor_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_word_q;

	logic                 accept;
	kind_t                kind_in;
	logic                 idx_ok;
	logic                 pos_ok;
	logic [POS_W-1:0]     start_bit;
	logic                 term_emit;
	logic                 out_free;

	logic                 dense_we;
	logic [WORD_BITS-1:0] dense_wdata;
	logic                 dense_re;
	logic [WORD_BITS-1:0] dense_rdata;
	logic                 acc_we;
	logic [IDX_W-1:0]     acc_waddr;
	logic [WORD_BITS-1:0] acc_wdata;
	logic                 acc_re;
	logic [IDX_W-1:0]     acc_raddr;
	logic [WORD_BITS-1:0] acc_rdata;

	pk_ctl_t              pk_ctl;
	pk_out_t              pk_out;

	// Input decode
	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid & items.ready;
	assign kind_in     = kind_t'(items.kind);
	assign idx_ok      = (items.word_index < NUM_WORDS);
	assign pos_ok      = (items.position < NUM_BITS);
	// Product bit 0 comes from dense bit (n - p) mod n
	assign start_bit   = (items.position == '0) ? '0 : (NUM_BITS - items.position);
	assign out_free    = !out_valid_q || results.ready;

	// Dense store: loads write, term sweep reads in order
	assign dense_we    = accept && (kind_in == KIND_LOAD) && idx_ok;
	assign dense_wdata = (items.word_index == LAST_WORD) ? (items.dense_word & TOP_MASK)
		: items.dense_word;
	assign dense_re    = (state_q == ST_TERM);

	sdcm_ram #(.WIDTH(WORD_BITS), .DEPTH(POLY_WORDS)) u_dense_ram (
		.clk   (clk),
		.we    (dense_we),
		.waddr (items.word_index),
		.wdata (dense_wdata),
		.re    (dense_re),
		.raddr (ra_q),
		.rdata (dense_rdata)
	);

	// Packer aligns the rotated stream
	assign pk_ctl.valid = rv_s1 && (state_q == ST_TERM);
	assign pk_ctl.first = rfirst_s1;
	assign pk_ctl.top   = rtop_s1;

	sdcm_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pk_ctl),
		.off    (off_q),
		.word   (dense_rdata),
		.out    (pk_out)
	);

	assign term_emit = pk_out.emit && (state_q == ST_TERM);

	// Accumulator: read ahead for emitted word, XOR back in the next cycle; clear sweep writes zero
	assign acc_re    = term_emit || (accept && (kind_in == KIND_READ) && idx_ok);
	assign acc_raddr = (state_q == ST_TERM) ? wcnt_q : items.word_index;
	assign acc_we    = (state_q == ST_CLEAR) || ew_v_s1;
	assign acc_waddr = (state_q == ST_CLEAR) ? wcnt_q : ew_idx_s1;
	assign acc_wdata = (state_q == ST_CLEAR) ? '0 : (acc_rdata ^ ew_s1);

	sdcm_ram #(.WIDTH(WORD_BITS), .DEPTH(POLY_WORDS)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.re    (acc_re),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			wcnt_q      <= '0;
			ra_q        <= '0;
			off_q       <= '0;
			first_q     <= 1'b0;
			rv_s1       <= 1'b0;
			rfirst_s1   <= 1'b0;
			rtop_s1     <= 1'b0;
			ew_v_s1     <= 1'b0;
			ew_idx_s1   <= '0;
			roor_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Dense read pipeline follows the read issue
			rv_s1     <= dense_re;
			rfirst_s1 <= dense_re && first_q;
			rtop_s1   <= (ra_q == LAST_WORD);
			ew_v_s1   <= term_emit;
			ew_idx_s1 <= wcnt_q;
			// Result beat: a new one replaces the taken one in the same cycle
			if ((state_q == ST_RDOUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind_in)
							KIND_TERM: begin
								if (pos_ok) begin
									ra_q    <= start_bit[POS_W-1:OFF_W];
									off_q   <= start_bit[OFF_W-1:0];
									first_q <= 1'b1;
									wcnt_q  <= '0;
									state_q <= ST_TERM;
								end
							end
							KIND_READ: begin
								roor_q  <= !idx_ok;
								state_q <= ST_RDOUT;
							end
							KIND_CLEAR: begin
								wcnt_q  <= '0;
								state_q <= ST_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLEAR: begin
					wcnt_q <= wcnt_q + IDX_W'(1);
					if (wcnt_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TERM: begin
					first_q <= 1'b0;
					ra_q    <= (ra_q == LAST_WORD) ? '0 : (ra_q + IDX_W'(1));
					if (term_emit) begin
						wcnt_q <= wcnt_q + IDX_W'(1);
						if (wcnt_q == LAST_WORD) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				ST_RDOUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (term_emit) begin
			ew_s1 <= (wcnt_q == LAST_WORD) ? (pk_out.data & TOP_MASK) : pk_out.data;
		end
		if ((state_q == ST_RDOUT) && out_free) begin
			out_word_q <= roor_q ? '0 : acc_rdata;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.result_word = out_word_q;
endmodule

`default_nettype wire

// ===== rtl/core/sdcm_checker.sv =====
// Checker: port-level properties of the multiplier core, bound to the top level.
`default_nettype none

module sdcm_checker
	import sdcm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [1:0]           kind,
	input logic [POS_W-1:0]     position,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [WORD_BITS-1:0] result_word
);
	logic in_beat;
	assign in_beat = in_valid && in_ready;

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_word))
		else $error("result beat dropped or changed while stalled");

	// A load leaves the block ready
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && (kind == KIND_LOAD) |=> in_ready)
		else $error("load beat did not return to ready");

	// Clear and in-range terms occupy the block
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && ((kind == KIND_CLEAR) || ((kind == KIND_TERM) && (position < NUM_BITS)))
		|=> !in_ready)
		else $error("block ready right after a clear or term beat");

	// A fresh result beat must have a matching read beat before it
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_beat && (kind == KIND_READ), 2))
		else $error("result beat without a matching read beat");
endmodule

bind sparse_dense_cyclic_gf2_multiply_core sdcm_checker u_sdcm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (items.valid),
	.in_ready    (items.ready),
	.kind        (items.kind),
	.position    (items.position),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.result_word (results.result_word)
);

`default_nettype wire

// ===== sim/tb_sparse_dense_cyclic_gf2_multiply_core.sv =====
// Testbench: sparse-dense cyclic GF(2) multiplier checked against a bit-vector product model.

module tb_sparse_dense_cyclic_gf2_multiply_core;
	import sdcm_pkg::*;

	localparam int CLK_HIGH       = 6;
	localparam int CLK_LOW        = 6;
	localparam int RESET_CYCLES   = 8;
	localparam int RANDOM_ITEMS   = 100;
	localparam int DRAIN_STRIDE   = 40;
	localparam int SETTLE_CYCLES  = 300;
	localparam int TIMEOUT_CYCLES = 1_000_000;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		kind_t                kind;
		logic [IDX_W-1:0]     word_index;
		logic [WORD_BITS-1:0] dense_word;
		logic [POS_W-1:0]     position;
		bit                   drain;
	} item_beat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Driven copies of the channel inputs, known from time zero
	logic                 item_valid    = 1'b0;
	logic [1:0]           item_kind     = KIND_LOAD;
	logic [IDX_W-1:0]     item_index    = '0;
	logic [WORD_BITS-1:0] item_word     = '0;
	logic [POS_W-1:0]     item_position = '0;
	logic                 result_ready  = 1'b0;

	sdcm_item_if   items_ch();
	sdcm_result_if results_ch();

	assign items_ch.valid      = item_valid;
	assign items_ch.kind       = item_kind;
	assign items_ch.word_index = item_index;
	assign items_ch.dense_word = item_word;
	assign items_ch.position   = item_position;
	assign results_ch.ready    = result_ready;

	sparse_dense_cyclic_gf2_multiply_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch)
	);

	// Product model state: dense store padded to whole words, accumulator as one vector
	logic [POLY_WORDS*WORD_BITS-1:0] dense_words  = '0;
	logic [POLY_BITS-1:0]            product_bits = '0;

	item_beat_t           pending_items[$];
	logic [WORD_BITS-1:0] expected_words[$];
	int                   accepted_items = 0;
	int                   total_items    = 0;
	int                   failures       = 0;
	bit                   drain_next     = 1'b0;

	always begin
		#CLK_HIGH clk = 1'b1;
		#CLK_LOW clk = 1'b0;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	function automatic logic [WORD_BITS-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Mostly legal degrees, some past the top that the block must ignore
	function automatic int pick_position();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(POLY_BITS, (1 << POS_W) - 1);
		if ($urandom_range(0, 19) == 0)
			return ($urandom_range(0, 1) != 0) ? POLY_BITS - 1 : 0;
		return $urandom_range(0, POLY_BITS - 1);
	endfunction

	function automatic int pick_index();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(POLY_WORDS, (1 << IDX_W) - 1);
		if ($urandom_range(0, 4) == 0)
			return POLY_WORDS - 1;
		return $urandom_range(0, POLY_WORDS - 1);
	endfunction

	// Fields a kind does not use get random content
	task automatic add_beat(input kind_t kind, input int idx, input logic [WORD_BITS-1:0] word,
		input int pos);
		item_beat_t beat;
		beat.kind       = kind;
		beat.word_index = IDX_W'($urandom);
		beat.dense_word = rand_word();
		beat.position   = POS_W'($urandom);
		beat.drain      = drain_next;
		if (kind == KIND_LOAD || kind == KIND_READ)
			beat.word_index = IDX_W'(idx);
		if (kind == KIND_LOAD)
			beat.dense_word = word;
		if (kind == KIND_TERM)
			beat.position = POS_W'(pos);
		drain_next = 1'b0;
		pending_items.push_back(beat);
	endtask

	// Apply one accepted beat to the product model
	task automatic update_product(input item_beat_t beat);
		logic [POLY_BITS-1:0]            dense_bits;
		logic [POLY_WORDS*WORD_BITS-1:0] padded;
		logic [WORD_BITS-1:0]            word;
		int                              idx;
		int                              pos;
		idx = int'(beat.word_index);
		pos = int'(beat.position);
		case (beat.kind)
			KIND_LOAD: begin
				if (idx < POLY_WORDS) begin
					word = beat.dense_word;
					if (beat.word_index == LAST_WORD)
						word &= TOP_MASK;
					dense_words[idx*WORD_BITS +: WORD_BITS] = word;
				end
			end
			KIND_TERM: begin
				// cyclic rotate up by pos; a shift by the full width yields zero
				if (pos < POLY_BITS) begin
					dense_bits = dense_words[POLY_BITS-1:0];
					product_bits ^= (dense_bits << pos) | (dense_bits >> (POLY_BITS - pos));
				end
			end
			KIND_READ: begin
				padded = '0;
				padded[POLY_BITS-1:0] = product_bits;
				if (idx < POLY_WORDS)
					expected_words.push_back(padded[idx*WORD_BITS +: WORD_BITS]);
				else
					expected_words.push_back('0);
			end
			default: begin
				product_bits = '0;
			end
		endcase
	endtask

	task automatic note_failure(input string what, input logic [WORD_BITS-1:0] want,
		input logic [WORD_BITS-1:0] got);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("mismatch (%s): expected %h got %h", what, want, got);
	endtask

	// Idle rates per third of the run: receiver heavy first, then sender, then none
	function automatic int sender_idle_pct();
		if (accepted_items < total_items / 3)
			return 38;
		if (accepted_items < (2 * total_items) / 3)
			return 74;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (accepted_items < total_items / 3)
			return 74;
		if (accepted_items < (2 * total_items) / 3)
			return 38;
		return 0;
	endfunction

	// Item driver: a new beat only once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		item_beat_t beat;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || items_ch.ready) begin
			if (pending_items.size() == 0) begin
				item_valid <= 1'b0;
			end else if (pending_items[0].drain && (item_valid || expected_words.size() != 0)) begin
				// hold off until every read has returned
				item_valid <= 1'b0;
			end else if ($urandom_range(0, 99) < sender_idle_pct()) begin
				item_valid <= 1'b0;
			end else begin
				beat = pending_items.pop_front();
				item_valid    <= 1'b1;
				item_kind     <= beat.kind;
				item_index    <= beat.word_index;
				item_word     <= beat.dense_word;
				item_position <= beat.position;
			end
		end
	end

	// Result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
		end
	end

	// Monitor: predict on accepted items, check accepted results in order
	always @(posedge clk) begin
		item_beat_t           seen;
		logic [WORD_BITS-1:0] want;
		if (arst_n) begin
			if (items_ch.valid && items_ch.ready) begin
				seen.kind       = kind_t'(items_ch.kind);
				seen.word_index = items_ch.word_index;
				seen.dense_word = items_ch.dense_word;
				seen.position   = items_ch.position;
				seen.drain      = 1'b0;
				update_product(seen);
				accepted_items <= accepted_items + 1;
			end
			if (results_ch.valid && results_ch.ready) begin
				if (expected_words.size() == 0) begin
					note_failure("unexpected beat", '0, results_ch.result_word);
				end else begin
					want = expected_words.pop_front();
					if (results_ch.result_word !== want)
						note_failure("result_word", want, results_ch.result_word);
				end
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int w;
		int roll;
		int count;
		int random_start;
		int next_drain;

		// Whole dense operand first, so no term ever reads an unwritten word
		for (w = 0; w < POLY_WORDS; w++)
			add_beat(KIND_LOAD, w, (w == POLY_WORDS - 1) ? '1 : rand_word(), 0);

		// Directed: index and degree extremes, ignored items, masking, clear
		add_beat(KIND_LOAD, POLY_WORDS, '1, 0);
		add_beat(KIND_LOAD, (1 << IDX_W) - 1, '1, 0);
		add_beat(KIND_READ, 0, '0, 0);
		add_beat(KIND_TERM, 0, '0, 0);
		add_beat(KIND_READ, 0, '0, 0);
		add_beat(KIND_READ, POLY_WORDS - 1, '0, 0);
		add_beat(KIND_TERM, 0, '0, POLY_BITS - 1);
		add_beat(KIND_READ, 0, '0, 0);
		add_beat(KIND_READ, POLY_WORDS - 1, '0, 0);
		add_beat(KIND_TERM, 0, '0, POLY_BITS);
		add_beat(KIND_TERM, 0, '0, (1 << POS_W) - 1);
		add_beat(KIND_READ, 1, '0, 0);
		add_beat(KIND_READ, POLY_WORDS, '0, 0);
		add_beat(KIND_READ, (1 << IDX_W) - 1, '0, 0);
		add_beat(KIND_TERM, 0, '0, WORD_BITS);
		add_beat(KIND_TERM, 0, '0, WORD_BITS);
		add_beat(KIND_READ, 1, '0, 0);
		add_beat(KIND_CLEAR, 0, '0, 0);
		add_beat(KIND_READ, 0, '0, 0);
		add_beat(KIND_LOAD, POLY_WORDS - 1, '1, 0);
		add_beat(KIND_LOAD, 0, '0, 0);
		add_beat(KIND_TERM, 0, '0, 1);
		add_beat(KIND_READ, POLY_WORDS - 1, '0, 0);
		add_beat(KIND_READ, 0, '0, 0);

		// Random: mostly load/clear/terms/reads jobs, some noise
		random_start = pending_items.size();
		next_drain = DRAIN_STRIDE;
		while (pending_items.size() < random_start + RANDOM_ITEMS) begin
			if (pending_items.size() - random_start >= next_drain) begin
				drain_next = 1'b1;
				next_drain += DRAIN_STRIDE;
			end
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				add_beat(kind_t'($urandom_range(0, 3)), $urandom_range(0, (1 << IDX_W) - 1),
					rand_word(), $urandom_range(0, (1 << POS_W) - 1));
			end else begin
				count = $urandom_range(0, 3);
				for (w = 0; w < count; w++)
					add_beat(KIND_LOAD, pick_index(), rand_word(), 0);
				if ($urandom_range(0, 3) != 0)
					add_beat(KIND_CLEAR, 0, '0, 0);
				count = $urandom_range(1, 4);
				for (w = 0; w < count; w++)
					add_beat(KIND_TERM, 0, '0, pick_position());
				count = $urandom_range(2, 6);
				for (w = 0; w < count; w++)
					add_beat(KIND_READ, pick_index(), '0, 0);
			end
		end
		total_items = pending_items.size();

		// Wait for the last beat to go in and every read to come back
		while (pending_items.size() != 0 || item_valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_words.size() != 0)
			note_failure("missing beat", expected_words[0], '0);

		if (failures == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_CYCLES * (CLK_HIGH + CLK_LOW));
		$display("FAILED: results differ");
		$finish;
	end

endmodule
